>>> design/pkgt_pkg.sv
// shared types and constants of the pair key group table
// no dependencies

package pkgt_pkg;

    localparam int KEY_W   = 64;
    localparam int GID_W   = 10;
    localparam int ROW_W   = 16;
    localparam int STAT_W  = 3;
    localparam int IDATA_W = 160;
    localparam int ODATA_W = 160;

    typedef enum logic [STAT_W-1:0] {
        ST_EXISTING = 3'd0,
        ST_NEW      = 3'd1,
        ST_NULL     = 3'd2,
        ST_FULL     = 3'd3,
        ST_READ     = 3'd4,
        ST_UNKNOWN  = 3'd5
    } t_status;

    localparam logic OP_CONSUME = 1'b0;
    localparam logic OP_READ    = 1'b1;

endpackage

>>> design/pkgt_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies

module pkgt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/pair_key_group_table_unit.sv
// pair key group table: hash table with linear probing over a bucket ram and a key ram
// depends on pkgt_pkg and pkgt_ram
// a null row or unknown group goes straight to the result, a read does one key ram read,
// and a consume hashes and then probes; throughput: one request at a time, and each
// probed bucket in use costs a bucket ram read, then a key ram read
// reset: synchronous, active low; afterwards the bucket ram is cleared one entry a
// cycle over all BUCKET_COUNT entries, during which no request is accepted

module pair_key_group_table_unit
    import pkgt_pkg::*;
#(
    parameter int MAX_GROUPS   = 1024,
    parameter int BUCKET_COUNT = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // first_key, second_key, first_null, second_null, row_tag, group_index, zero fill
    input  logic [IDATA_W-1:0] s_axis_tdata,
    // operation
    input  logic               s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // group_num, row_echo, key_first_out, key_second_out, zero fill
    output logic [ODATA_W-1:0] m_axis_tdata,
    // status
    output logic [STAT_W-1:0]  m_axis_tuser
);

    localparam int GIW = $clog2(MAX_GROUPS);
    localparam int CW  = $clog2(MAX_GROUPS + 1);
    localparam int BW  = $clog2(BUCKET_COUNT);
    localparam int PW  = $clog2(BUCKET_COUNT + 1);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_HASH, S_BKT, S_KEY, S_RD, S_DONE
    } t_state;

    t_state r_state;

    // input fields
    logic [KEY_W-1:0] w_k1, w_k2;
    logic             w_n1, w_n2;
    logic [ROW_W-1:0] w_tag;
    logic [GID_W-1:0] w_gidx;
    assign w_k1   = s_axis_tdata[63:0];
    assign w_k2   = s_axis_tdata[127:64];
    assign w_n1   = s_axis_tdata[128];
    assign w_n2   = s_axis_tdata[129];
    assign w_tag  = s_axis_tdata[145:130];
    assign w_gidx = s_axis_tdata[155:146];

    logic [KEY_W-1:0] r_k1, r_k2;
    logic [BW-1:0]    r_pos;
    logic [PW-1:0]    r_probe;
    logic [CW-1:0]    r_used;
    logic [BW-1:0]    r_clr;

    t_status          r_res_stat;
    logic [GID_W-1:0] r_res_gid;
    logic [ROW_W-1:0] r_res_row;
    logic [KEY_W-1:0] r_res_k1, r_res_k2;

    logic             r_out_valid;
    t_status          r_out_stat;
    logic [GID_W-1:0] r_out_gid;
    logic [ROW_W-1:0] r_out_row;
    logic [KEY_W-1:0] r_out_k1, r_out_k2;

    // memories
    logic            w_bkt_we;
    logic [BW-1:0]   w_bkt_waddr, w_bkt_raddr;
    logic [GIW:0]    w_bkt_wdata, w_bkt_rdata;
    logic            w_key_we;
    logic [GIW-1:0]  w_key_waddr, w_key_raddr;
    logic [2*KEY_W-1:0] w_key_wdata, w_key_rdata;

    pkgt_ram #(.WIDTH(GIW + 1), .DEPTH(BUCKET_COUNT)) u_bkt_ram (
        .i_clk   (i_clk),
        .i_we    (w_bkt_we),
        .i_waddr (w_bkt_waddr),
        .i_wdata (w_bkt_wdata),
        .i_raddr (w_bkt_raddr),
        .o_rdata (w_bkt_rdata)
    );

    pkgt_ram #(.WIDTH(2 * KEY_W), .DEPTH(MAX_GROUPS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (w_key_waddr),
        .i_wdata (w_key_wdata),
        .i_raddr (w_key_raddr),
        .o_rdata (w_key_rdata)
    );

    logic           w_bkt_hit_used;
    logic [GIW-1:0] w_bkt_gid;
    assign w_bkt_hit_used = w_bkt_rdata[GIW];
    assign w_bkt_gid      = w_bkt_rdata[GIW-1:0];

    logic [2*KEY_W-1:0] w_pair;
    assign w_pair = {r_k2, r_k1};

    // home bucket: xor fold of both keys, brought below BUCKET_COUNT
    logic [BW-1:0] w_fold, w_home;
    always_comb begin
        w_fold = '0;
        for (int i = 0; i < 2 * KEY_W; i++) begin
            w_fold[i % BW] = w_fold[i % BW] ^ w_pair[i];
        end
        if (32'(w_fold) >= 32'(BUCKET_COUNT)) begin
            w_home = BW'(32'(w_fold) - 32'(BUCKET_COUNT));
        end else begin
            w_home = w_fold;
        end
    end

    logic [BW-1:0] w_next_pos;
    logic [PW-1:0] w_next_probe;
    logic          w_match, w_accept, w_out_free, w_gidx_ok, w_tbl_full;
    assign w_next_pos   = (32'(r_pos) == 32'(BUCKET_COUNT - 1)) ? '0 : r_pos + 1'b1;
    assign w_next_probe = r_probe + 1'b1;
    assign w_match      = (w_key_rdata == w_pair);
    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_out_free   = !r_out_valid || m_axis_tready;
    assign w_gidx_ok    = 32'(w_gidx) < 32'(r_used);
    assign w_tbl_full   = 32'(r_used) >= 32'(MAX_GROUPS);

    always_comb begin
        w_bkt_we    = 1'b0;
        w_bkt_waddr = r_pos;
        w_bkt_wdata = {1'b1, GIW'(r_used)};
        w_bkt_raddr = r_pos;
        w_key_we    = 1'b0;
        w_key_waddr = GIW'(r_used);
        w_key_wdata = w_pair;
        w_key_raddr = w_bkt_gid;
        unique case (r_state)
            S_CLR: begin
                w_bkt_we    = 1'b1;
                w_bkt_waddr = r_clr;
                w_bkt_wdata = '0;
            end
            S_IDLE: begin
                w_key_raddr = GIW'(w_gidx);
            end
            S_HASH: begin
                w_bkt_raddr = w_home;
            end
            S_BKT: begin
                if (!w_bkt_hit_used && !w_tbl_full) begin
                    w_bkt_we = 1'b1;
                    w_key_we = 1'b1;
                end
            end
            S_KEY: begin
                w_bkt_raddr = w_next_pos;
            end
            default: begin
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_state == S_DONE && w_out_free) || (r_out_valid && !m_axis_tready);
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == 32'(BUCKET_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_k1       <= w_k1;
                        r_k2       <= w_k2;
                        r_res_k1   <= '0;
                        r_res_k2   <= '0;
                        r_res_gid  <= (s_axis_tuser == OP_READ) ? w_gidx : '0;
                        r_res_row  <= (s_axis_tuser == OP_READ) ? '0 : w_tag;
                        if (s_axis_tuser == OP_READ) begin
                            if (w_gidx_ok) begin
                                r_state <= S_RD;
                            end else begin
                                r_res_stat <= ST_UNKNOWN;
                                r_state    <= S_DONE;
                            end
                        end else if (w_n1 || w_n2) begin
                            r_res_stat <= ST_NULL;
                            r_state    <= S_DONE;
                        end else begin
                            r_state <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    r_pos   <= w_home;
                    r_probe <= '0;
                    r_state <= S_BKT;
                end
                S_BKT: begin
                    if (!w_bkt_hit_used) begin
                        if (w_tbl_full) begin
                            r_res_stat <= ST_FULL;
                            r_res_gid  <= '0;
                        end else begin
                            r_res_stat <= ST_NEW;
                            r_res_gid  <= GID_W'(r_used);
                            r_used     <= r_used + 1'b1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_res_gid <= GID_W'(w_bkt_gid);
                        r_state   <= S_KEY;
                    end
                end
                S_KEY: begin
                    if (w_match) begin
                        r_res_stat <= ST_EXISTING;
                        r_state    <= S_DONE;
                    end else if (32'(w_next_probe) == 32'(BUCKET_COUNT)) begin
                        r_res_stat <= ST_FULL;
                        r_res_gid  <= '0;
                        r_state    <= S_DONE;
                    end else begin
                        r_pos   <= w_next_pos;
                        r_probe <= w_next_probe;
                        r_state <= S_BKT;
                    end
                end
                S_RD: begin
                    r_res_stat <= ST_READ;
                    r_res_k1   <= w_key_rdata[KEY_W-1:0];
                    r_res_k2   <= w_key_rdata[2*KEY_W-1:KEY_W];
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_stat  <= r_res_stat;
                        r_out_gid   <= r_res_gid;
                        r_out_row   <= r_res_row;
                        r_out_k1    <= r_res_k1;
                        r_out_k2    <= r_res_k2;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_stat;
    assign m_axis_tdata  = {6'd0, r_out_k2, r_out_k1, r_out_row, r_out_gid};

endmodule
